// File: rtl/core/eb_pkg.sv
// Shared constants for the filled ellipse band rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package eb_pkg;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int COORD_BITS_DEF = 12;
    // walk error terms stay well below 2^31 for any legal size
    localparam int WALK_BITS      = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;
endpackage

// File: rtl/core/eb_front.sv
// Front part: checks a request, sets up and runs the midpoint walk,
// pushes unclipped band words into the queue. Depends on eb_pkg.
`timescale 1ns / 1ps
module eb_front
    import eb_pkg::*;
#(
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CB = COORD_BITS + 2,
    localparam int EW = 4 * CB + 2
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [COORD_BITS-1:0] rect_left,
    input  logic [COORD_BITS-1:0] rect_top,
    input  logic [COORD_BITS-1:0] rect_right,
    input  logic [COORD_BITS-1:0] rect_bottom,
    input  logic                  room,
    output logic                  push,
    output logic [EW-1:0]         push_data,
    output logic                  active
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_INIT1, S_INIT2, S_INIT3, S_WALK, S_LOWER, S_CENTRE
    } state_t;

    typedef logic signed [CB-1:0]        crd_t;
    typedef logic signed [WALK_BITS-1:0] acc_t;

    state_t state_reg, state_next;
    crd_t left_reg, top_reg, bw_reg, bh_reg, a_reg, b_reg, cx_reg, cy_reg;
    crd_t x_reg, y_reg, oy_reg, pl_reg, pt_reg, pr_reg, pb_reg;
    logic [1:0] wod_reg, hod_reg;
    acc_t aa_reg, bb0_reg, m1_reg, st_reg, tt_reg, sx_reg, w_reg, u_reg, v_reg;

    crd_t lcalc, wcalc, hcalc, ynew, ul, ur;
    logic bad, empty;

    assign lcalc = CB'($signed(rect_left));
    assign ynew  = y_reg - crd_t'(1);
    assign ul    = cx_reg - x_reg;
    assign ur    = ul + (x_reg <<< 1) + crd_t'(wod_reg);
    assign bad   = bw_reg < 0 || bh_reg < 0 || bw_reg > crd_t'(MAX_WIDTH)
                   || bh_reg > crd_t'(MAX_HEIGHT);
    assign empty = bw_reg == 0 || bh_reg == 0;
    assign wcalc = bw_reg - crd_t'(1);
    assign hcalc = bh_reg - crd_t'(1);
    assign active = state_reg != S_IDLE;

    always_comb
    begin
        push       = 1'b0;
        push_data  = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (bad)
                begin
                    push       = room;
                    push_data  = {crd_t'(0), crd_t'(0), crd_t'(0), crd_t'(0), 1'b1, 1'b1};
                    state_next = room ? S_IDLE : S_CHECK;
                end
                else if (empty)
                begin
                    push       = room;
                    push_data  = {left_reg, top_reg, left_reg + bw_reg,
                                  top_reg + bh_reg, 1'b1, 1'b0};
                    state_next = room ? S_IDLE : S_CHECK;
                end
                else
                    state_next = S_INIT1;
            end
            S_INIT1: state_next = S_INIT2;
            S_INIT2: state_next = S_INIT3;
            S_INIT3: state_next = S_WALK;
            S_WALK:
            begin
                if (y_reg <= 0)
                    state_next = S_CENTRE;
                else if (st_reg >= 0 && tt_reg < 0 && room)
                begin
                    push       = 1'b1;
                    push_data  = {ul, cy_reg - oy_reg, ur, cy_reg - ynew, 1'b0, 1'b0};
                    state_next = S_LOWER;
                end
            end
            S_LOWER:
            begin
                push       = room;
                push_data  = {pl_reg, pt_reg, pr_reg, pb_reg, 1'b0, 1'b0};
                state_next = room ? S_WALK : S_LOWER;
            end
            S_CENTRE:
            begin
                push       = room;
                push_data  = {left_reg, cy_reg - oy_reg, left_reg + bw_reg,
                              cy_reg + oy_reg + crd_t'(hod_reg), 1'b1, 1'b0};
                state_next = room ? S_IDLE : S_CENTRE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                left_reg <= lcalc;
                top_reg  <= CB'($signed(rect_top));
                bw_reg   <= CB'($signed(rect_right)) - lcalc;
                bh_reg   <= CB'($signed(rect_bottom)) - CB'($signed(rect_top));
            end
            S_CHECK:
            begin
                a_reg   <= wcalc >>> 1;
                b_reg   <= hcalc >>> 1;
                wod_reg <= {1'b0, wcalc[0]} + 2'd1;
                hod_reg <= {1'b0, hcalc[0]} + 2'd1;
                cx_reg  <= left_reg + (wcalc >>> 1);
                cy_reg  <= top_reg + (hcalc >>> 1);
            end
            S_INIT1:
            begin
                aa_reg  <= WALK_BITS'(a_reg) * WALK_BITS'(a_reg);
                bb0_reg <= WALK_BITS'(b_reg) * WALK_BITS'(b_reg);
            end
            S_INIT2: m1_reg <= aa_reg * WALK_BITS'(b_reg);
            S_INIT3:
            begin
                st_reg <= aa_reg - (m1_reg <<< 1) + (bb0_reg <<< 1);
                tt_reg <= bb0_reg - (m1_reg <<< 2) + (aa_reg <<< 1);
                sx_reg <= (bb0_reg <<< 2) + (bb0_reg <<< 1);
                w_reg  <= bb0_reg <<< 2;
                u_reg  <= (m1_reg <<< 2) - (aa_reg <<< 2) - (aa_reg <<< 1);
                v_reg  <= (m1_reg <<< 2) - (aa_reg <<< 2);
                x_reg  <= '0;
                y_reg  <= b_reg;
                oy_reg <= b_reg;
            end
            S_WALK:
            begin
                if (y_reg > 0)
                begin
                    if (st_reg < 0)
                    begin
                        st_reg <= st_reg + sx_reg;
                        tt_reg <= tt_reg + w_reg;
                        sx_reg <= sx_reg + (bb0_reg <<< 2);
                        w_reg  <= w_reg + (bb0_reg <<< 2);
                        x_reg  <= x_reg + crd_t'(1);
                    end
                    else if (tt_reg < 0)
                    begin
                        if (room)
                        begin
                            st_reg <= st_reg + sx_reg - v_reg;
                            tt_reg <= tt_reg + w_reg - u_reg;
                            sx_reg <= sx_reg + (bb0_reg <<< 2);
                            w_reg  <= w_reg + (bb0_reg <<< 2);
                            u_reg  <= u_reg - (aa_reg <<< 2);
                            v_reg  <= v_reg - (aa_reg <<< 2);
                            x_reg  <= x_reg + crd_t'(1);
                            y_reg  <= ynew;
                            oy_reg <= ynew;
                            // hold the mirrored lower band for S_LOWER to push
                            pl_reg <= ul;
                            pr_reg <= ur;
                            pt_reg <= cy_reg + ynew + crd_t'(hod_reg);
                            pb_reg <= cy_reg + oy_reg + crd_t'(hod_reg);
                        end
                    end
                    else
                    begin
                        tt_reg <= tt_reg - u_reg;
                        st_reg <= st_reg - v_reg;
                        u_reg  <= u_reg - (aa_reg <<< 2);
                        v_reg  <= v_reg - (aa_reg <<< 2);
                        y_reg  <= ynew;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

// File: rtl/core/eb_queue.sv
// Short queue of band words between the walk and the clipper.
// Depends on eb_pkg.
`timescale 1ns / 1ps
module eb_queue
    import eb_pkg::*;
#(
    parameter int WIDTH = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             nonempty,
    output logic             room
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_pop;

    assign nonempty = cnt_reg != '0;
    assign room     = cnt_reg < (AW+1)'(QUEUE_DEPTH);
    assign do_pop   = pop && nonempty;
    assign rdata    = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + AW'(1);
            if (do_pop)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(do_pop);
        end
    end
endmodule

// File: rtl/core/eb_back.sv
// Back part: clips each band word against the clip rectangle and
// registers the result word. Depends on eb_pkg.
`timescale 1ns / 1ps
module eb_back
    import eb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CB = COORD_BITS + 2,
    localparam int EW = 4 * CB + 2
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [EW-1:0]                in_data,
    input  logic signed [COORD_BITS-1:0] cl,
    input  logic signed [COORD_BITS-1:0] ct,
    input  logic signed [COORD_BITS-1:0] cr,
    input  logic signed [COORD_BITS-1:0] cb,
    output logic                         done,
    output logic [COORD_BITS-1:0]        fill_left,
    output logic [COORD_BITS-1:0]        fill_top,
    output logic [COORD_BITS-1:0]        fill_right,
    output logic [COORD_BITS-1:0]        fill_bottom,
    output logic                         visible,
    output logic                         bad_request,
    output logic                         last
);
    typedef logic signed [CB-1:0] crd_t;

    crd_t l, t, r, b, xl, xt, xr, xb, kl, kt, kr, kb;
    logic is_last, is_bad, clip_on, vis;
    logic done_reg;
    logic [COORD_BITS-1:0] l_reg, t_reg, r_reg, b_reg;
    logic vis_reg, bad_reg, last_reg;

    assign {l, t, r, b, is_last, is_bad} = in_data;
    assign xl = CB'(cl);
    assign xt = CB'(ct);
    assign xr = CB'(cr);
    assign xb = CB'(cb);
    assign clip_on = !(cr <= cl || cb <= ct);
    assign kl  = (clip_on && xl > l) ? xl : l;
    assign kt  = (clip_on && xt > t) ? xt : t;
    assign kr  = (clip_on && xr < r) ? xr : r;
    assign kb  = (clip_on && xb < b) ? xb : b;
    assign vis = !is_bad && kr > kl && kb > kt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        // drop coordinates of empty or refused bands
        l_reg    <= vis ? kl[COORD_BITS-1:0] : '0;
        t_reg    <= vis ? kt[COORD_BITS-1:0] : '0;
        r_reg    <= vis ? kr[COORD_BITS-1:0] : '0;
        b_reg    <= vis ? kb[COORD_BITS-1:0] : '0;
        vis_reg  <= vis;
        bad_reg  <= is_bad;
        last_reg <= is_last;
    end

    assign done        = done_reg;
    assign fill_left   = l_reg;
    assign fill_top    = t_reg;
    assign fill_right  = r_reg;
    assign fill_bottom = b_reg;
    assign visible     = vis_reg;
    assign bad_request = bad_reg;
    assign last        = last_reg;
endmodule

// File: rtl/core/filled_ellipse_band_rasterizer_top.sv
// Top level of the filled ellipse band rasterizer: clip registers,
// walk front, band queue and clipping back. Depends on eb_pkg and submodules.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. After the setup
// states S_CHECK and S_INIT1 to S_INIT3 the walk runs about a+b steps for
// half-width a and half-height b, with an S_LOWER state per band pair, then
// the centre band; results pass through the band queue and the back part's
// output register. One ellipse at a time: busy stays high until the walk is
// done and the queue is empty. Results come out one per cycle on done and
// cannot be held off by the receiver; the word with last set closes each
// ellipse. Clip registers are written through wr_en/wr_index/wr_data.
module filled_ellipse_band_rasterizer_top
    import eb_pkg::*;
#(
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [1:0]            wr_index,
    input  logic [COORD_BITS-1:0] wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] rect_left,
    input  logic [COORD_BITS-1:0] rect_top,
    input  logic [COORD_BITS-1:0] rect_right,
    input  logic [COORD_BITS-1:0] rect_bottom,
    output logic                  done,
    output logic [COORD_BITS-1:0] fill_left,
    output logic [COORD_BITS-1:0] fill_top,
    output logic [COORD_BITS-1:0] fill_right,
    output logic [COORD_BITS-1:0] fill_bottom,
    output logic                  visible,
    output logic                  bad_request,
    output logic                  last
);
    localparam int EW = 4 * (COORD_BITS + 2) + 2;

    logic signed [COORD_BITS-1:0] cl_reg, ct_reg, cr_reg, cb_reg;
    logic go, push, room, nonempty, active;
    logic [EW-1:0] wdata, rdata;

    assign busy = active || nonempty;
    assign go   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg <= '0;
            ct_reg <= '0;
            cr_reg <= '0;
            cb_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CLIP_LEFT:   cl_reg <= wr_data;
                REG_CLIP_TOP:    ct_reg <= wr_data;
                REG_CLIP_RIGHT:  cr_reg <= wr_data;
                REG_CLIP_BOTTOM: cb_reg <= wr_data;
                default: ;
            endcase
        end
    end

    eb_front #(
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WIDTH (MAX_WIDTH),
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .rect_left  (rect_left),
        .rect_top   (rect_top),
        .rect_right (rect_right),
        .rect_bottom(rect_bottom),
        .room       (room),
        .push       (push),
        .push_data  (wdata),
        .active     (active)
    );

    eb_queue #(
        .WIDTH(EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wdata   (wdata),
        .pop     (1'b1),
        .rdata   (rdata),
        .nonempty(nonempty),
        .room    (room)
    );

    eb_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (nonempty),
        .in_data    (rdata),
        .cl         (cl_reg),
        .ct         (ct_reg),
        .cr         (cr_reg),
        .cb         (cb_reg),
        .done       (done),
        .fill_left  (fill_left),
        .fill_top   (fill_top),
        .fill_right (fill_right),
        .fill_bottom(fill_bottom),
        .visible    (visible),
        .bad_request(bad_request),
        .last       (last)
    );
endmodule

// File: rtl/core/eb_checker.sv
// Port-level checks for the filled ellipse band rasterizer, bound to
// the top level. Depends on eb_pkg defaults only.
`timescale 1ns / 1ps
module eb_checker
    import eb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [COORD_BITS-1:0] fill_left,
    input logic signed [COORD_BITS-1:0] fill_top,
    input logic signed [COORD_BITS-1:0] fill_right,
    input logic signed [COORD_BITS-1:0] fill_bottom,
    input logic                         visible,
    input logic                         bad_request,
    input logic                         last
);
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_request |-> last && !visible)
        else $error("refused word without last or with visible");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !visible |-> fill_left == 0 && fill_top == 0
                             && fill_right == 0 && fill_bottom == 0)
        else $error("hidden word carries coordinates");

    a_vis_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && visible |-> fill_right > fill_left && fill_bottom > fill_top)
        else $error("visible word is empty");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");
endmodule

bind filled_ellipse_band_rasterizer_top eb_checker #(.COORD_BITS(COORD_BITS)) u_eb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .fill_left  (fill_left),
    .fill_top   (fill_top),
    .fill_right (fill_right),
    .fill_bottom(fill_bottom),
    .visible    (visible),
    .bad_request(bad_request),
    .last       (last)
);

// File: tb/sv/tb.sv
// Testbench for filled_ellipse_band_rasterizer_top: directed table, then random ellipses,
// each band checked against a behavioral band predictor. Depends on eb_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
    import eb_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int MAXH = MAX_HEIGHT_DEF;
    localparam int LIMIT = 400000;

    typedef logic [CB-1:0] coord_t;
    typedef struct packed {
        coord_t l, t, r, b;
        logic vis, bad, lst;
    } band_t;
    typedef struct {
        coord_t l, t, r, b;
        logic chk;
        band_t want;
    } row_t;

    logic clk, rst_n, wr_en, start, busy, done;
    logic [1:0] wr_index;
    coord_t wr_data, rect_left, rect_top, rect_right, rect_bottom;
    coord_t fill_left, fill_top, fill_right, fill_bottom;
    logic visible, bad_request, last;

    filled_ellipse_band_rasterizer_top uut (.*);

    band_t band_q[$];
    int clip_reg[4];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int sx(coord_t v);
        return int'($signed(v));
    endfunction

    function automatic void push_band(int l, int t, int w, int h, logic lst);
        band_t o;
        int r, b;
        r = l + w;
        b = t + h;
        if (!(clip_reg[2] <= clip_reg[0] || clip_reg[3] <= clip_reg[1]))
        begin
            if (clip_reg[0] > l) l = clip_reg[0];
            if (clip_reg[1] > t) t = clip_reg[1];
            if (clip_reg[2] < r) r = clip_reg[2];
            if (clip_reg[3] < b) b = clip_reg[3];
        end
        o.vis = (r > l) && (b > t);
        if (!o.vis)
        begin
            l = 0; t = 0; r = 0; b = 0;
        end
        o.l = coord_t'(l); o.t = coord_t'(t); o.r = coord_t'(r); o.b = coord_t'(b);
        o.bad = 0;
        o.lst = lst;
        band_q.push_back(o);
    endfunction

    // bad or empty box: one word; else walk a quadrant, queue band pairs, then the centre band
    function automatic void predict_bands(coord_t il, coord_t it, coord_t ir, coord_t ib);
        longint left, top, bw, bh, wd, ht, a, b, wod, hod, cx, cy, x, y, oy;
        longint aa2, aa4, bb, st, tt, px, dw, dh;
        band_t o;
        left = sx(il);
        top = sx(it);
        bw = sx(ir) - left;
        bh = sx(ib) - top;
        if (bw < 0 || bh < 0 || bw > MAXW || bh > MAXH)
        begin
            o = '0;
            o.bad = 1;
            o.lst = 1;
            band_q.push_back(o);
            return;
        end
        if (bw == 0 || bh == 0)
        begin
            push_band(left, top, bw, bh, 1);
            return;
        end
        wd = bw - 1; ht = bh - 1;
        a = wd / 2; b = ht / 2;
        wod = (wd & 1) + 1; hod = (ht & 1) + 1;
        cx = left + a; cy = top + b;
        x = 0; y = b; oy = b;
        aa2 = 2 * a * a; aa4 = 2 * aa2; bb = 2 * b * b;
        st = a * a * (1 - 2 * b) + bb;
        tt = b * b - aa2 * (2 * b - 1);
        while (y > 0)
        begin
            if (st < 0)
            begin
                st += bb * (2 * x + 3);
                x++;
                tt += 2 * bb * x;
            end
            else if (tt < 0)
            begin
                st += bb * (2 * x + 3) - aa4 * (y - 1);
                px = cx - x;
                dw = 2 * x + wod;
                x++;
                tt += 2 * bb * x - aa2 * (2 * y - 3);
                y--;
                dh = oy - y;
                push_band(px, cy - oy, dw, dh, 0);
                push_band(px, cy + y + hod, dw, dh, 0);
                oy = y;
            end
            else
            begin
                tt -= aa2 * (2 * y - 3);
                y--;
                st -= aa4 * y;
            end
        end
        push_band(cx - a, cy - oy, wd + 1, 2 * oy + hod, 1);
    endfunction

    always @(posedge clk)
    begin
        band_t got, exp_b;
        if (rst_n && done)
        begin
            got = {fill_left, fill_top, fill_right, fill_bottom, visible, bad_request, last};
            if (band_q.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_b = band_q.pop_front();
                if (got !== exp_b)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_b, got);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        if (!quiet)
            while ($urandom_range(99) < 19)
                @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (band_q.size() != 0)
            @(negedge clk);
        while (n < 20)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic set_clip(int l, int t, int r, int b);
        int v[4];
        v = '{l, t, r, b};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            wr_en = 1;
            wr_index = 2'(i);
            wr_data = coord_t'(v[i]);
            clip_reg[i] = sx(coord_t'(v[i]));
        end
        @(negedge clk);
        wr_en = 0;
    endtask

    // present one word and hold start until it is taken
    task automatic send_rect(coord_t l, coord_t t, coord_t r, coord_t b);
        idle_gap();
        rect_left = l; rect_top = t; rect_right = r; rect_bottom = b;
        start = 1;
        // busy is settled between edges; the word goes at the next rising edge
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_bands(l, t, r, b);
        @(negedge clk);
        start = 0;
        rect_left = coord_t'($urandom);
        rect_right = coord_t'($urandom);
    endtask

    task automatic random_phase(int count, int spread);
        int l, t;
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= count / 3 && i < count / 2);
            l = $urandom_range(4095) - 2048;
            t = $urandom_range(4095) - 2048;
            if ($urandom_range(9) == 0)
                send_rect(coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom));
            else
                send_rect(coord_t'(l), coord_t'(t),
                    coord_t'(l + $urandom_range(spread)), coord_t'(t + $urandom_range(MAXH)));
        end
        quiet = 0;
    endtask

    row_t dir_rows[$];

    initial
    begin
        row_t rw;
        clip_reg = '{0, 0, 0, 0};
        rst_n = 0; wr_en = 0; wr_index = REG_CLIP_LEFT; wr_data = '0; start = 0;
        rect_left = '0; rect_top = '0; rect_right = '0; rect_bottom = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // expected words typed in for refusals and empty boxes
        dir_rows.push_back('{12'd0, 12'd0, 12'd0, 12'd0, 1, '{0, 0, 0, 0, 0, 0, 1}});
        dir_rows.push_back('{12'd10, 12'd0, 12'd5, 12'd5, 1, '{0, 0, 0, 0, 0, 1, 1}});
        dir_rows.push_back('{12'd0, 12'd10, 12'd5, 12'd5, 1, '{0, 0, 0, 0, 0, 1, 1}});
        dir_rows.push_back('{12'd0, 12'd0, 12'd257, 12'd5, 1, '{0, 0, 0, 0, 0, 1, 1}});
        dir_rows.push_back('{12'd0, 12'd0, 12'd5, 12'd65, 1, '{0, 0, 0, 0, 0, 1, 1}});
        dir_rows.push_back('{12'h800, 12'h800, 12'h7FF, 12'h7FF, 1, '{0, 0, 0, 0, 0, 1, 1}});
        dir_rows.push_back('{12'd3, 12'd3, 12'd3, 12'd9, 1, '{0, 0, 0, 0, 0, 0, 1}});
        dir_rows.push_back('{12'd0, 12'd0, 12'd256, 12'd64, 0, '0});
        dir_rows.push_back('{12'h800, 12'h800, 12'h900, 12'h840, 0, '0});
        dir_rows.push_back('{12'h700, 12'h7C0, 12'h7FF, 12'h7FF, 0, '0});
        dir_rows.push_back('{12'd0, 12'd0, 12'd1, 12'd1, 0, '0});
        dir_rows.push_back('{12'd0, 12'd0, 12'd2, 12'd2, 0, '0});
        dir_rows.push_back('{12'd5, 12'd5, 12'd6, 12'd69, 0, '0});
        dir_rows.push_back('{12'd5, 12'd5, 12'd261, 12'd6, 0, '0});
        dir_rows.push_back('{12'hFF0, 12'hFF0, 12'd17, 12'd20, 0, '0});
        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            send_rect(rw.l, rw.t, rw.r, rw.b);
            if (rw.chk)
            begin
                void'(band_q.pop_back());
                band_q.push_back(rw.want);
            end
        end
        drain();

        set_clip(-10, -10, 20, 15);
        send_rect(12'hFF0, 12'hFF0, 12'd30, 12'd30);
        send_rect(12'd100, 12'd100, 12'd120, 12'd120);
        random_phase(10, 60);
        drain();
        set_clip(-2048, -2048, 2047, 2047);
        random_phase(45, MAXW);
        drain();
        set_clip(-100, 0, 100, 40);
        random_phase(20, 200);
        drain();
        set_clip(2047, 2047, -2048, -2048);
        random_phase(25, 80);
        drain();
        set_clip($urandom_range(4095) - 2048, -30, $urandom_range(4095) - 2048, 30);
        random_phase(15, 120);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/eb_pkg.sv
rtl/core/eb_front.sv
rtl/core/eb_queue.sv
rtl/core/eb_back.sv
rtl/core/filled_ellipse_band_rasterizer_top.sv
rtl/core/eb_checker.sv
tb/sv/tb.sv
